### rtl/tfp_pkg.sv
// Shared constants for the text frame parser: characters, status codes and hash seeds.
`default_nettype none
package tfp_pkg;

  // Framing and field characters.
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Verdict status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FRAMING = 3'd1;
  localparam logic [2:0] ST_FIELD   = 3'd2;
  localparam logic [2:0] ST_LENGTH  = 3'd3;
  localparam logic [2:0] ST_CSUM    = 3'd4;

  // Result kinds.
  localparam logic KIND_MSG     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // djb2 seed and the seed terms of the one- and two-byte field hashes.
  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam logic [31:0] HASH_ONE_K = HASH_SEED * 32'd33;
  localparam logic [31:0] HASH_TWO_K = HASH_ONE_K * 32'd33;
  // Two one-byte fields (command, ttl) and three two-byte fields (length, source, dest).
  localparam logic [31:0] FIELD_HASH_K = 32'd2 * HASH_ONE_K + 32'd3 * HASH_TWO_K;

  // Field limits.
  localparam logic [31:0] LIM_WORD   = 32'd65535;
  localparam logic [31:0] LIM_BYTE   = 32'd255;
  localparam logic [31:0] LIM_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG    = 32'h8000_0000;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

endpackage
`default_nettype wire

### rtl/text_frame_parser_with_checksum.sv
// Text frame parser: decodes framed decimal fields, forwards message bytes, checks the sum.
//
//   Channel  Direction  Handshake              Payload
//   in_*     input      in_valid / in_ready    data_byte[8], end_of_frame[1]
//   out_*    output     out_valid / out_ready  kind, message_byte, status, parsed fields
//
// One byte is taken per cycle while in_ready is high; each transfer updates the parse state
// at once and loads the result register in the same edge, so a result shows in the cycle
// after its byte. The result register is the only buffer: in_ready is low only while a
// result is held and out_ready is low. Reset (rst_n, synchronous) returns the parser to
// waiting for the opening brace, with no result pending. After each verdict the frame state clears.
`default_nettype none
module text_frame_parser_with_checksum (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_message_byte,
  output logic [2:0]       out_status,
  output logic [15:0]      out_source_node,
  output logic [15:0]      out_dest_node,
  output logic [7:0]       out_hop_limit,
  output logic [7:0]       out_command_code,
  output logic [15:0]      out_payload_length
);
  import tfp_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN = 3'd0,
    PH_SRC  = 3'd1,
    PH_DST  = 3'd2,
    PH_TTL  = 3'd3,
    PH_CMD  = 3'd4,
    PH_SUM  = 3'd5,
    PH_LEN  = 3'd6,
    PH_MSG  = 3'd7
  } phase_t;

  // Frame state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] source_acc_r, source_acc_nxt;
  logic [15:0] dest_acc_r, dest_acc_nxt;
  logic [7:0]  hop_acc_r, hop_acc_nxt;
  logic [7:0]  command_acc_r, command_acc_nxt;
  logic [31:0] claimed_sum_r, claimed_sum_nxt;
  logic        claimed_neg_r, claimed_neg_nxt;
  logic [15:0] length_acc_r, length_acc_nxt;
  logic        digit_seen_r, digit_seen_nxt;
  logic        field_fault_r, field_fault_nxt;
  logic [16:0] payload_count_r, payload_count_nxt;
  logic [31:0] payload_hash_r, payload_hash_nxt;
  logic        payload_fault_r, payload_fault_nxt;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_msg_r, out_msg_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [15:0] out_src_r, out_src_nxt;
  logic [15:0] out_dst_r, out_dst_nxt;
  logic [7:0]  out_hop_r, out_hop_nxt;
  logic [7:0]  out_cmd_r, out_cmd_nxt;
  logic [15:0] out_len_r, out_len_nxt;

  logic        in_fire;
  logic        is_digit;
  logic        is_space;
  logic [3:0]  digit;
  logic [31:0] acc_sel;
  logic [31:0] lim_sel;
  logic [35:0] acc_mul;
  logic        acc_over;
  logic [31:0] acc_new;
  logic [9:0]  low_bytes;
  logic [31:0] field_hash;
  logic [31:0] total_hash;
  logic [31:0] claim_val;
  logic [2:0]  verdict;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Character classes.
  assign is_digit = (in_data_byte >= CH_ZERO) && (in_data_byte <= CH_NINE);
  assign is_space = (in_data_byte == CH_SPACE) || (in_data_byte == CH_NUL) ||
                    ((in_data_byte >= CH_TAB) && (in_data_byte <= CH_CR));
  assign digit    = 4'(in_data_byte - CH_ZERO);

  // Shared decimal accumulator: picks the field of the current phase and its limit.
  always_comb begin
    unique case (phase_r)
      PH_SRC:  begin acc_sel = 32'(source_acc_r);  lim_sel = LIM_WORD; end
      PH_DST:  begin acc_sel = 32'(dest_acc_r);    lim_sel = LIM_WORD; end
      PH_TTL:  begin acc_sel = 32'(hop_acc_r);     lim_sel = LIM_BYTE; end
      PH_CMD:  begin acc_sel = 32'(command_acc_r); lim_sel = LIM_BYTE; end
      PH_SUM:  begin
        acc_sel = claimed_sum_r;
        lim_sel = claimed_neg_r ? LIM_NEG : LIM_POS;
      end
      PH_LEN:  begin acc_sel = 32'(length_acc_r);  lim_sel = LIM_WORD; end
      default: begin acc_sel = 32'(length_acc_r);  lim_sel = LIM_WORD; end
    endcase
  end

  assign acc_mul  = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + 36'(digit);
  assign acc_over = acc_mul > 36'(lim_sel);
  assign acc_new  = acc_over ? lim_sel : acc_mul[31:0];

  // Checksum: the field hashes reduce to a constant plus small weighted byte terms.
  assign low_bytes  = 10'(length_acc_r[7:0]) + 10'(source_acc_r[7:0]) +
                      10'(dest_acc_r[7:0]);
  assign field_hash = FIELD_HASH_K + 32'(command_acc_r) + 32'(hop_acc_r) +
                      {17'd0, low_bytes, 5'd0} + 32'(low_bytes) +
                      32'(length_acc_r[15:8]) + 32'(source_acc_r[15:8]) +
                      32'(dest_acc_r[15:8]);
  assign total_hash = field_hash + payload_hash_r;
  assign claim_val  = claimed_neg_r ? (32'd0 - claimed_sum_r) : claimed_sum_r;

  // Verdict priority: framing, field, length, checksum.
  always_comb begin
    priority if (in_data_byte != CH_CLOSE || phase_r == PH_OPEN) begin
      verdict = ST_FRAMING;
    end else if (phase_r != PH_MSG || field_fault_r || payload_fault_r ||
                 payload_count_r == 17'd0) begin
      verdict = ST_FIELD;
    end else if (payload_count_r != {1'b0, length_acc_r}) begin
      verdict = ST_LENGTH;
    end else if (total_hash != claim_val) begin
      verdict = ST_CSUM;
    end else begin
      verdict = ST_OK;
    end
  end

  // Next frame state and result.
  always_comb begin
    phase_nxt         = phase_r;
    source_acc_nxt    = source_acc_r;
    dest_acc_nxt      = dest_acc_r;
    hop_acc_nxt       = hop_acc_r;
    command_acc_nxt   = command_acc_r;
    claimed_sum_nxt   = claimed_sum_r;
    claimed_neg_nxt   = claimed_neg_r;
    length_acc_nxt    = length_acc_r;
    digit_seen_nxt    = digit_seen_r;
    field_fault_nxt   = field_fault_r;
    payload_count_nxt = payload_count_r;
    payload_hash_nxt  = payload_hash_r;
    payload_fault_nxt = payload_fault_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_msg_nxt    = out_msg_r;
    out_status_nxt = out_status_r;
    out_src_nxt    = out_src_r;
    out_dst_nxt    = out_dst_r;
    out_hop_nxt    = out_hop_r;
    out_cmd_nxt    = out_cmd_r;
    out_len_nxt    = out_len_r;

    if (in_fire) begin
      priority if (in_end_of_frame) begin
        // Final byte: report the verdict and clear the frame.
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_VERDICT;
        out_msg_nxt    = 8'd0;
        out_status_nxt = verdict;
        out_src_nxt    = source_acc_r;
        out_dst_nxt    = dest_acc_r;
        out_hop_nxt    = hop_acc_r;
        out_cmd_nxt    = command_acc_r;
        out_len_nxt    = length_acc_r;

        phase_nxt         = PH_OPEN;
        source_acc_nxt    = 16'd0;
        dest_acc_nxt      = 16'd0;
        hop_acc_nxt       = 8'd0;
        command_acc_nxt   = 8'd0;
        claimed_sum_nxt   = 32'd0;
        claimed_neg_nxt   = 1'b0;
        length_acc_nxt    = 16'd0;
        digit_seen_nxt    = 1'b0;
        field_fault_nxt   = 1'b0;
        payload_count_nxt = 17'd0;
        payload_hash_nxt  = HASH_SEED;
        payload_fault_nxt = 1'b0;
      end else if (phase_r == PH_OPEN) begin
        // Opening brace; anything else poisons the frame until its final byte.
        if (!field_fault_r && in_data_byte == CH_OPEN) begin
          phase_nxt = PH_SRC;
        end else begin
          field_fault_nxt = 1'b1;
        end
      end else if (phase_r == PH_MSG) begin
        // Message byte: count, hash and pass it on.
        if (payload_count_r != COUNT_MAX) begin
          payload_count_nxt = payload_count_r + 17'd1;
        end
        payload_hash_nxt = {payload_hash_r[26:0], 5'd0} + payload_hash_r +
                           32'(in_data_byte);
        if (is_space) begin
          payload_fault_nxt = 1'b1;
        end
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = KIND_MSG;
        out_msg_nxt    = in_data_byte;
        out_status_nxt = ST_OK;
        out_src_nxt    = 16'd0;
        out_dst_nxt    = 16'd0;
        out_hop_nxt    = 8'd0;
        out_cmd_nxt    = 8'd0;
        out_len_nxt    = 16'd0;
      end else if (in_data_byte == CH_SEMI) begin
        // Field separator; an empty field is a fault.
        if (!digit_seen_r) begin
          field_fault_nxt = 1'b1;
        end
        digit_seen_nxt = 1'b0;
        phase_nxt      = phase_t'(phase_r + 3'd1);
      end else if (is_digit) begin
        digit_seen_nxt = 1'b1;
        if (acc_over) begin
          field_fault_nxt = 1'b1;
        end
        unique case (phase_r)
          PH_SRC:  source_acc_nxt  = acc_new[15:0];
          PH_DST:  dest_acc_nxt    = acc_new[15:0];
          PH_TTL:  hop_acc_nxt     = acc_new[7:0];
          PH_CMD:  command_acc_nxt = acc_new[7:0];
          PH_SUM:  claimed_sum_nxt = acc_new;
          default: length_acc_nxt  = acc_new[15:0];
        endcase
      end else if (phase_r == PH_SUM && in_data_byte == CH_MINUS &&
                   !digit_seen_r && !claimed_neg_r) begin
        claimed_neg_nxt = 1'b1;
      end else begin
        field_fault_nxt = 1'b1;
      end
    end
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_OPEN;
      source_acc_r    <= 16'd0;
      dest_acc_r      <= 16'd0;
      hop_acc_r       <= 8'd0;
      command_acc_r   <= 8'd0;
      claimed_sum_r   <= 32'd0;
      claimed_neg_r   <= 1'b0;
      length_acc_r    <= 16'd0;
      digit_seen_r    <= 1'b0;
      field_fault_r   <= 1'b0;
      payload_count_r <= 17'd0;
      payload_hash_r  <= HASH_SEED;
      payload_fault_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      source_acc_r    <= source_acc_nxt;
      dest_acc_r      <= dest_acc_nxt;
      hop_acc_r       <= hop_acc_nxt;
      command_acc_r   <= command_acc_nxt;
      claimed_sum_r   <= claimed_sum_nxt;
      claimed_neg_r   <= claimed_neg_nxt;
      length_acc_r    <= length_acc_nxt;
      digit_seen_r    <= digit_seen_nxt;
      field_fault_r   <= field_fault_nxt;
      payload_count_r <= payload_count_nxt;
      payload_hash_r  <= payload_hash_nxt;
      payload_fault_r <= payload_fault_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_msg_r    <= out_msg_nxt;
    out_status_r <= out_status_nxt;
    out_src_r    <= out_src_nxt;
    out_dst_r    <= out_dst_nxt;
    out_hop_r    <= out_hop_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_message_byte   = out_msg_r;
  assign out_status         = out_status_r;
  assign out_source_node    = out_src_r;
  assign out_dest_node      = out_dst_r;
  assign out_hop_limit      = out_hop_r;
  assign out_command_code   = out_cmd_r;
  assign out_payload_length = out_len_r;

`ifndef NO_ASSERTIONS
  // A final-byte transfer always leaves the parser waiting for a new frame.
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_end_of_frame) |=> (phase_r == PH_OPEN && payload_count_r == 17'd0))
    else $error("frame state not cleared after final byte");

  // Message bytes are only counted once the message has been reached.
  a_count_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_MSG) |-> (payload_count_r == 17'd0 && !payload_fault_r))
    else $error("message count outside the message phase");

  // A passed-on message byte carries a clear status and zero fields.
  a_msg_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_MSG) |->
      (out_status_r == ST_OK && out_src_r == 16'd0 && out_len_r == 16'd0))
    else $error("message result carries verdict fields");

  // A verdict status is one of the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_VERDICT) |-> (out_status_r <= ST_CSUM))
    else $error("verdict status out of range");
`endif

endmodule
`default_nettype wire
